### hdl/hamming_7_4_stream_codec_defines.svh
// assertion macros shared by the codec rtl
`ifndef HAMMING_7_4_STREAM_CODEC_DEFINES_SVH
`define HAMMING_7_4_STREAM_CODEC_DEFINES_SVH

// same-cycle implication, checked on every clock edge out of reset
`define HMC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hamming codec check failed");

// next-cycle implication
`define HMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hamming codec check failed");

`endif

### hdl/hmc_pkg.sv
// types, codes and constants of the hamming stream codec
package hmc_pkg;

    // operation codes
    localparam logic [1:0] OP_ENCODE = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_NOISE1 = 2'd2;
    localparam logic [1:0] OP_NOISE2 = 2'd3;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_OPERATION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTENDED  = 1'd1;

    // group sizes in bits
    localparam logic [3:0] NIBBLE_W   = 4'd4;
    localparam logic [3:0] CODE_W     = 4'd7;
    localparam logic [3:0] EXT_CODE_W = 4'd8;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_out;
        logic       double_error;
    } out_item_t;

    // per-message state, all held counts stay below one byte
    typedef struct packed {
        logic [6:0] in_bits;
        logic [2:0] in_count;
        logic [6:0] out_bits;
        logic [2:0] out_count;
        logic [2:0] noise_pos;
        logic       aborted;
    } msg_state_t;

    // what one processed item leaves for the output side
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  count;
        logic        last;
        logic        double_error;
    } step_result_t;

endpackage

### hdl/hamming_7_4_stream_codec.sv
// top level of the hamming(7,4) / extended (8,4) stream codec
//
// input channel in_valid / in_ready / in_item carries one message byte per
// item, bits used least significant first, with last_in on the final byte.
// output channel out_valid / out_ready / out_item carries packed result bytes,
// last_out on the final byte of the message and double_error once an
// extended decode has hit an uncorrectable group.
// operation and extended are set through cfg_wr_en / cfg_index / cfg_data
// into registers; the user must write them only while no message item is
// in flight, which the block does not enforce. an accepted item waits in
// the input register until the result buffer is free, is coded in a single
// pass into the result buffer, and its first byte is offered from there.
// an item yields zero to three bytes, sent one at a time on the single
// output port, so the rate is one item per cycle when each item gives one
// byte and the receiver does not stall; encode gives more bytes per item.
// the input register takes a new item in the same cycle that the last byte
// of the buffer leaves, and a stalled receiver simply holds the buffer and,
// behind it, the input register.
// reset clears configuration, message state and both holding stages.
`include "hamming_7_4_stream_codec_defines.svh"

module hamming_7_4_stream_codec (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [hmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hmc_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output hmc_pkg::out_item_t                 out_item
);
    import hmc_pkg::*;

    // configuration registers
    logic [1:0]   operation_reg;
    logic         extended_reg;

    // input holding register
    in_item_t     in_item_reg;
    logic         in_full_reg;

    // message state carried from item to item
    msg_state_t   state_reg;
    msg_state_t   state_next;
    step_result_t step_res;

    // result buffer: bytes still to send, lowest byte first
    logic [23:0]  data_reg;
    logic [1:0]   left_reg;
    logic         last_reg;
    logic         err_reg;

    logic         proc_fire;
    logic         out_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= OP_ENCODE;
            extended_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OPERATION: operation_reg <= cfg_data;
                REG_EXTENDED:  extended_reg  <= cfg_data[0];
            endcase
        end
    end

    hmc_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .operation  (operation_reg),
        .extended   (extended_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    assign out_fire  = out_valid && out_ready;
    // code the held item once the buffer is empty or empties this cycle
    assign proc_fire = in_full_reg &&
                       ((left_reg == 2'd0) || ((left_reg == 2'd1) && out_ready));
    assign in_ready  = !in_full_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_full_reg <= 1'b1;
        else if (proc_fire)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            left_reg  <= 2'd0;
        end
        else if (proc_fire)
        begin
            state_reg <= state_next;
            left_reg  <= step_res.count;
        end
        else if (out_fire)
        begin
            left_reg  <= left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            data_reg <= step_res.data;
            last_reg <= step_res.last;
            err_reg  <= step_res.double_error;
        end
        else if (out_fire)
        begin
            data_reg <= data_reg >> 8;
        end
    end

    assign out_valid             = (left_reg != 2'd0);
    assign out_item.byte_out     = data_reg[7:0];
    assign out_item.last_out     = last_reg && (left_reg == 2'd1);
    assign out_item.double_error = err_reg;

    // message state is already cleared when the final byte leaves
    `HMC_ASSERT_IMPL(a_clear_after_last, out_fire && out_item.last_out, state_reg == '0)
    // an aborted message holds no input bits
    `HMC_ASSERT_IMPL(a_abort_drops_input, state_reg.aborted, state_reg.in_count == 3'd0)
    // an abort lasts until the final byte of the message
    `HMC_ASSERT_NEXT(a_abort_sticks, proc_fire && state_reg.aborted && !in_item_reg.last_in, state_reg.aborted)

endmodule

### hdl/hmc_step.sv
// per-item datapath: cuts up to two groups, codes them and packs the output bits
module hmc_step (
    input  hmc_pkg::msg_state_t   state,
    input  hmc_pkg::in_item_t     item,
    input  logic [1:0]            operation,
    input  logic                  extended,
    output hmc_pkg::msg_state_t   state_next,
    output hmc_pkg::step_result_t result
);
    import hmc_pkg::*;

    typedef struct packed {
        logic [7:0] bits;
        logic [3:0] len;
        logic       dbl;
        logic [2:0] npos;
    } group_out_t;

    function automatic logic [7:0] noise_mask(input logic [2:0] pos);
        logic [7:0] m;
        if (pos == 3'd0)
            m = 8'h80;
        else
            m = 8'h01 << (pos - 3'd1);
        return m;
    endfunction

    function automatic group_out_t code_group(
        input logic [7:0] grp,
        input logic [1:0] op,
        input logic       ext,
        input logic [2:0] npos
    );
        group_out_t r;
        logic [6:0] c;
        logic [2:0] s;
        logic [6:0] fix;
        logic [7:0] flip;
        logic [7:0] cmask;
        r      = '0;
        r.npos = npos;
        c      = grp[6:0];
        cmask  = ext ? 8'hFF : 8'h7F;
        unique case (op)
            OP_ENCODE:
            begin
                r.bits[0] = grp[0] ^ grp[1] ^ grp[3];
                r.bits[1] = grp[0] ^ grp[2] ^ grp[3];
                r.bits[2] = grp[0];
                r.bits[3] = grp[1] ^ grp[2] ^ grp[3];
                r.bits[4] = grp[1];
                r.bits[5] = grp[2];
                r.bits[6] = grp[3];
                r.bits[7] = ext & (^r.bits[6:0]);
                r.len     = ext ? EXT_CODE_W : CODE_W;
            end
            OP_DECODE:
            begin
                s[2] = c[3] ^ c[4] ^ c[5] ^ c[6];
                s[1] = c[1] ^ c[2] ^ c[5] ^ c[6];
                s[0] = c[0] ^ c[2] ^ c[4] ^ c[6];
                fix  = (s == 3'd0) ? 7'd0 : (7'd1 << (s - 3'd1));
                c    = c ^ fix;
                r.bits = {4'd0, c[6], c[5], c[4], c[2]};
                r.len  = NIBBLE_W;
                // nonzero syndrome with even raw parity: two bits are wrong
                r.dbl  = ext && (s != 3'd0) && !(^grp);
            end
            OP_NOISE1, OP_NOISE2:
            begin
                flip = noise_mask(npos);
                if (op == OP_NOISE2)
                    flip = flip ^ noise_mask(npos + 3'd1);
                r.bits = (grp ^ flip) & cmask;
                r.len  = ext ? EXT_CODE_W : CODE_W;
                r.npos = npos + ((op == OP_NOISE2) ? 3'd2 : 3'd1);
            end
        endcase
        return r;
    endfunction

    logic [3:0]  grp_size;
    logic [7:0]  grp_mask;
    logic [14:0] acc0;
    logic [14:0] acc1;
    logic [14:0] acc2;
    logic [3:0]  cnt0;
    logic [3:0]  cnt1;
    logic [3:0]  cnt2;
    logic        go1;
    logic        go2;
    logic        err;
    group_out_t  g1;
    group_out_t  g2;
    logic [23:0] obuf;
    logic [4:0]  ocnt;
    logic [1:0]  nfull;
    msg_state_t  st;

    assign grp_size = (operation == OP_ENCODE) ? NIBBLE_W :
                      (extended ? EXT_CODE_W : CODE_W);
    assign grp_mask = 8'((9'd1 << grp_size) - 9'd1);

    // append the byte above the held bits
    assign acc0 = 15'(state.in_bits) | (15'(item.byte_in) << state.in_count);
    assign cnt0 = 4'(state.in_count) + 4'd8;

    assign go1  = !state.aborted && (cnt0 >= grp_size);
    assign g1   = code_group(acc0[7:0] & grp_mask, operation, extended, state.noise_pos);
    assign acc1 = acc0 >> grp_size;
    assign cnt1 = cnt0 - grp_size;

    assign go2  = go1 && !g1.dbl && (cnt1 >= grp_size);
    assign g2   = code_group(acc1[7:0] & grp_mask, operation, extended, g1.npos);
    assign acc2 = acc1 >> grp_size;
    assign cnt2 = cnt1 - grp_size;

    assign err  = (go1 && g1.dbl) || (go2 && g2.dbl);

    always_comb
    begin
        obuf = 24'(state.out_bits);
        ocnt = 5'(state.out_count);
        if (go1 && !g1.dbl)
        begin
            obuf = obuf | (24'(g1.bits) << ocnt);
            ocnt = ocnt + 5'(g1.len);
        end
        if (go2 && !g2.dbl)
        begin
            obuf = obuf | (24'(g2.bits) << ocnt);
            ocnt = ocnt + 5'(g2.len);
        end
    end

    assign nfull = ocnt[4:3];

    always_comb
    begin
        st           = state;
        st.aborted   = state.aborted | err;
        st.out_bits  = 7'(obuf >> {nfull, 3'b000});
        st.out_count = ocnt[2:0];
        if (go2)
            st.noise_pos = g2.npos;
        else if (go1)
            st.noise_pos = g1.npos;
        if (err)
        begin
            st.in_bits  = '0;
            st.in_count = '0;
        end
        else if (go2)
        begin
            st.in_bits  = 7'(acc2);
            st.in_count = 3'(cnt2);
        end
        else if (go1)
        begin
            st.in_bits  = 7'(acc1);
            st.in_count = 3'(cnt1);
        end
        else if (!state.aborted)
        begin
            st.in_bits  = 7'(acc0);
            st.in_count = 3'(cnt0);
        end
    end

    // the final byte carries the leftover bits, or is an empty marker byte when no other byte goes out
    always_comb
    begin
        result.data         = obuf;
        result.last         = item.last_in;
        result.double_error = st.aborted;
        if (item.last_in && ((ocnt[2:0] != 3'd0) || (nfull == 2'd0)))
            result.count = nfull + 2'd1;
        else
            result.count = nfull;
    end

    assign state_next = item.last_in ? msg_state_t'('0) : st;

endmodule
